// ===== hw/rtl/flcc_pkg.sv =====
// Shared types, constants and CRC helpers of the framed line CRC checker.
package flcc_pkg;

  // Character codes
  localparam logic [7:0] NEWLINE = 8'h0a;
  localparam logic [7:0] SPACE   = 8'h20;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF = 8'h66;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;

  // CRC-16 constants
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hffff;
  localparam logic [15:0] CRC_XOROUT = 16'hffff;

  // Line prefixes and their lengths
  localparam logic [4:0] WRAP_LEN   = 5'd5;
  localparam logic [4:0] SCAN_LEN   = 5'd12;
  localparam logic [4:0] WROTE_LEN  = 5'd15;
  localparam logic [4:0] UNABLE_LEN = 5'd15;
  localparam logic [4:0] POS_MAX    = 5'd31;
  localparam logic [4:0] WRAP_HIT_POS = 5'd4;

  localparam logic [7:0] PFX_WRAP [5] = '{"W", "R", "A", "P", " "};
  localparam logic [7:0] PFX_SCAN [12] =
    '{"S", "C", "A", "N", "_", "R", "E", "S", "U", "L", "T", " "};
  localparam logic [7:0] PFX_WROTE [15] =
    '{"W", "r", "o", "t", "e", " ", "s", "t", "u", "f", "f", " ", "i", "n", " "};
  localparam logic [7:0] PFX_UNABLE [15] =
    '{"U", "n", "a", "b", "l", "e", " ", "t", "o", " ", "m", "a", "k", "e", " "};

  // Prefix flag bit positions
  localparam int unsigned FLAG_WRAP   = 0;
  localparam int unsigned FLAG_SCAN   = 1;
  localparam int unsigned FLAG_WROTE  = 2;
  localparam int unsigned FLAG_UNABLE = 3;
  localparam logic [3:0]  FLAGS_ALL   = 4'hf;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BEFORE_HEX,
    PH_IN_HEX,
    PH_BEFORE_DEC,
    PH_IN_DEC,
    PH_DONE,
    PH_FAILED
  } wrap_phase_e;

  typedef enum logic [2:0] {
    CLS_WRAP_OK        = 3'd0,
    CLS_WRAP_MALFORMED = 3'd1,
    CLS_SCAN_LINE      = 3'd2,
    CLS_INFO           = 3'd3,
    CLS_OTHER          = 3'd4
  } line_class_e;

  typedef enum logic [1:0] {
    VER_OK          = 2'd0,
    VER_NO_WRAP     = 2'd1,
    VER_BAD_CRC     = 2'd2,
    VER_NOT_CHECKED = 2'd3
  } verdict_e;

  typedef struct packed {
    line_class_e line_class;
    verdict_e    verdict;
    logic [15:0] expected_crc;
    logic [15:0] computed_crc;
    logic [15:0] lines_counted;
    logic [15:0] errors_counted;
  } result_t;

  // One byte of CRC-16, MSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (r[15]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Hex digit decode: bit 4 is valid, bits 3:0 the value
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'd0;
    if (b >= CHAR_0 && b <= CHAR_9) begin
      v = {1'b1, 4'(b - CHAR_0)};
    end else if (b >= CHAR_LA && b <= CHAR_LF) begin
      v = {1'b1, 4'(b - CHAR_LA + 8'd10)};
    end else if (b >= CHAR_UA && b <= CHAR_UF) begin
      v = {1'b1, 4'(b - CHAR_UA + 8'd10)};
    end
    return v;
  endfunction

endpackage

// ===== hw/rtl/flcc_if.sv =====
// Valid/ready stream interfaces for received bytes and line results.
interface flcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface flcc_result_if;
  import flcc_pkg::*;
  logic        valid;
  logic        ready;
  line_class_e line_class;
  verdict_e    verdict;
  logic [15:0] expected_crc;
  logic [15:0] computed_crc;
  logic [15:0] lines_counted;
  logic [15:0] errors_counted;

  modport source (output valid, output line_class, output verdict, output expected_crc,
                  output computed_crc, output lines_counted, output errors_counted,
                  input ready);
  modport sink (input valid, input line_class, input verdict, input expected_crc,
                input computed_crc, input lines_counted, input errors_counted,
                output ready);
endinterface

// ===== hw/rtl/flcc_in_stage.sv =====
// Input register holding one received byte beat.
module flcc_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  output logic       ready_o,
  input  logic       consume_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  import flcc_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // Take a new beat when empty or when the held one is consumed
  assign ready_o = !valid_q || consume_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
endmodule

// ===== hw/rtl/flcc_line_engine.sv =====
// Per-byte line parser: prefix match, WRAP field parse, chained CRC and counters.
module flcc_line_engine #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_i,
  input  logic             slot_free_i,
  output logic             consume_o,
  output logic             res_load_o,
  output flcc_pkg::result_t res_o
);
  import flcc_pkg::*;

  logic [4:0]             pos_q, pos_d;
  logic [3:0]             flags_q, flags_d, flags_m;
  wrap_phase_e            phase_q, phase_d, phase_p, phase_line;
  logic [15:0]            exp_q, exp_d, exp_p;
  logic                   pend_q, pend_d, pend_p;
  logic [15:0]            seed_q, seed_d, seed_p;
  logic [15:0]            tail_q, tail_d, tail_p, tail_crc;
  logic [15:0]            lcrc_q, lcrc_d, lcrc_p;
  logic [COUNT_WIDTH-1:0] lines_q, lines_d, lines_n;
  logic [COUNT_WIDTH-1:0] errs_q, errs_d, errs_n;
  logic                   is_nl, is_space, is_digit, wrap_hit;
  logic [4:0]             hexv;
  logic [15:0]            computed;
  line_class_e            cls;
  verdict_e               verdict;
  logic                   line_bump, err_bump, scan_line;

  // Byte decode
  assign is_nl    = byte_i == NEWLINE;
  assign is_space = byte_i == SPACE;
  assign is_digit = byte_i >= CHAR_0 && byte_i <= CHAR_9;
  assign hexv     = hex_val(byte_i);

  // Hold a newline until the result slot is free; other bytes always flow
  assign consume_o  = byte_valid_i && (!is_nl || slot_free_i);
  assign res_load_o = consume_o && is_nl;

  // Drop prefix flags on mismatch
  always_comb begin
    flags_m = flags_q;
    if (pos_q < WRAP_LEN && byte_i != PFX_WRAP[pos_q[2:0]]) begin
      flags_m[FLAG_WRAP] = 1'b0;
    end
    if (pos_q < SCAN_LEN && byte_i != PFX_SCAN[pos_q[3:0]]) begin
      flags_m[FLAG_SCAN] = 1'b0;
    end
    if (pos_q < WROTE_LEN && byte_i != PFX_WROTE[pos_q[3:0]]) begin
      flags_m[FLAG_WROTE] = 1'b0;
    end
    if (pos_q < UNABLE_LEN && byte_i != PFX_UNABLE[pos_q[3:0]]) begin
      flags_m[FLAG_UNABLE] = 1'b0;
    end
  end

  assign wrap_hit = pos_q == WRAP_HIT_POS && flags_m[FLAG_WRAP];

  // Next state of the WRAP field parser
  always_comb begin
    phase_p = phase_q;
    case (phase_q)
      PH_BEFORE_HEX: begin
        if (!is_space) begin
          phase_p = hexv[4] ? PH_IN_HEX : PH_FAILED;
        end
      end
      PH_IN_HEX: begin
        if (!hexv[4]) begin
          phase_p = is_space ? PH_BEFORE_DEC : PH_FAILED;
        end
      end
      PH_BEFORE_DEC: begin
        if (is_digit) begin
          phase_p = PH_IN_DEC;
        end else if (!is_space) begin
          phase_p = PH_FAILED;
        end
      end
      PH_IN_DEC: begin
        if (!is_digit) begin
          phase_p = PH_DONE;
        end
      end
      default: begin
        phase_p = phase_q;
      end
    endcase
    phase_line = wrap_hit ? PH_BEFORE_HEX : phase_p;
    phase_d    = phase_q;
    if (consume_o) begin
      phase_d = is_nl ? PH_IDLE : phase_line;
    end
  end

  // Field data of the WRAP parser
  assign tail_crc = crc_update(tail_q, byte_i);

  always_comb begin
    exp_p  = exp_q;
    pend_p = pend_q;
    seed_p = seed_q;
    tail_p = tail_q;
    case (phase_q)
      PH_BEFORE_HEX: begin
        if (!is_space && hexv[4]) begin
          exp_p = {exp_q[11:0], hexv[3:0]};
        end
      end
      PH_IN_HEX: begin
        if (hexv[4]) begin
          exp_p = {exp_q[11:0], hexv[3:0]};
        end else if (is_space) begin
          tail_p = CRC_INIT;
        end
      end
      PH_BEFORE_DEC: begin
        tail_p = tail_crc;
        if (is_digit && byte_i != CHAR_0) begin
          pend_p = 1'b1;
        end
      end
      PH_IN_DEC: begin
        tail_p = tail_crc;
        if (is_digit) begin
          if (byte_i != CHAR_0) begin
            pend_p = 1'b1;
          end
        end else begin
          seed_p = tail_crc ^ CRC_XOROUT;
        end
      end
      default: begin
        tail_p = tail_q;
      end
    endcase
    if (wrap_hit) begin
      exp_p  = 16'h0000;
      pend_p = 1'b0;
    end
  end

  // Line CRC, chained from the seed
  assign lcrc_p   = crc_update(lcrc_q, byte_i);
  assign computed = lcrc_p ^ CRC_XOROUT;

  // Classify the finished line
  always_comb begin
    cls       = CLS_OTHER;
    verdict   = VER_NOT_CHECKED;
    line_bump = 1'b0;
    err_bump  = 1'b0;
    scan_line = 1'b0;
    if (flags_m[FLAG_WRAP]) begin
      line_bump = 1'b1;
      if (phase_line == PH_DONE) begin
        cls = CLS_WRAP_OK;
      end else begin
        cls      = CLS_WRAP_MALFORMED;
        err_bump = 1'b1;
      end
    end else if (flags_m[FLAG_SCAN]) begin
      cls       = CLS_SCAN_LINE;
      line_bump = 1'b1;
      scan_line = 1'b1;
      if (!pend_p) begin
        verdict = VER_NO_WRAP;
      end else if (exp_p != computed) begin
        verdict = VER_BAD_CRC;
      end else begin
        verdict = VER_OK;
      end
      err_bump = verdict != VER_OK;
    end else if (flags_m[FLAG_WROTE] || flags_m[FLAG_UNABLE]) begin
      cls = CLS_INFO;
    end else begin
      cls       = CLS_OTHER;
      line_bump = 1'b1;
      err_bump  = 1'b1;
    end
  end

  // Saturating counters
  assign lines_n = (line_bump && lines_q != '1) ? lines_q + COUNT_WIDTH'(1) : lines_q;
  assign errs_n  = (err_bump && errs_q != '1) ? errs_q + COUNT_WIDTH'(1) : errs_q;

  always_comb begin
    res_o.line_class     = cls;
    res_o.verdict        = verdict;
    res_o.expected_crc   = exp_p;
    res_o.computed_crc   = computed;
    res_o.lines_counted  = 16'(lines_n);
    res_o.errors_counted = 16'(errs_n);
  end

  // Advance state on each consumed byte; restart the line at newline
  always_comb begin
    pos_d   = pos_q;
    flags_d = flags_q;
    exp_d   = exp_q;
    pend_d  = pend_q;
    seed_d  = seed_q;
    tail_d  = tail_q;
    lcrc_d  = lcrc_q;
    lines_d = lines_q;
    errs_d  = errs_q;
    if (consume_o) begin
      exp_d  = exp_p;
      seed_d = seed_p;
      if (is_nl) begin
        pos_d   = 5'd0;
        flags_d = FLAGS_ALL;
        pend_d  = pend_p && !scan_line;
        tail_d  = CRC_INIT;
        lcrc_d  = seed_p ^ CRC_XOROUT;
        lines_d = lines_n;
        errs_d  = errs_n;
      end else begin
        pos_d   = (pos_q < POS_MAX) ? pos_q + 5'd1 : pos_q;
        flags_d = flags_m;
        pend_d  = pend_p;
        tail_d  = tail_p;
        lcrc_d  = lcrc_p;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 5'd0;
      flags_q <= FLAGS_ALL;
      phase_q <= PH_IDLE;
      exp_q   <= 16'h0000;
      pend_q  <= 1'b0;
      seed_q  <= 16'h0000;
      tail_q  <= CRC_INIT;
      lcrc_q  <= CRC_XOROUT;
      lines_q <= '0;
      errs_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      flags_q <= flags_d;
      phase_q <= phase_d;
      exp_q   <= exp_d;
      pend_q  <= pend_d;
      seed_q  <= seed_d;
      tail_q  <= tail_d;
      lcrc_q  <= lcrc_d;
      lines_q <= lines_d;
      errs_q  <= errs_d;
    end
  end
endmodule

// ===== hw/rtl/flcc_out_stage.sv =====
// Result register that holds one line result until the receiver takes it.
module flcc_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  flcc_pkg::result_t res_i,
  output logic              slot_free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output flcc_pkg::result_t res_o
);
  import flcc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // Slot frees up when empty or when the held beat leaves this cycle
  assign slot_free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
endmodule

// ===== hw/rtl/framed_line_crc_checker_unit.sv =====
// Top level of the framed line CRC checker.
//
// Usage: received text bytes enter on rx_i, one byte per beat. Each newline
// byte produces one result beat on res_o with the line class, the verdict of
// a scan line, the stored and computed CRC, and the saturating line
// and error counters (low 16 bits). Other bytes produce no result.
// Path: a byte is registered in the input register when accepted, and the
// engine processes it from there; a newline loads the result register as it
// is consumed, and the result shows on res_o from that register.
// Throughput: one byte per cycle while no newline waits on the result slot;
// the CRC step, the prefix compare and the WRAP field parse are one registered pass per byte.
// Stall: while a result waits on res_o, bytes that are not a newline keep
// flowing; a newline waits in the input register until the result slot
// frees, and rx_i.ready drops while it waits.
// Reset: clears the parser, the chain seed (zero), the stored CRC, the
// pending wrapper and both counters; the first line is chained from seed 0.
module framed_line_crc_checker_unit #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  flcc_byte_if.sink            rx_i,
  flcc_result_if.source        res_o
);
  import flcc_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       consume;
  logic       res_load;
  logic       slot_free;
  result_t    res_next;
  result_t    res_q;

  flcc_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_i.valid),
    .byte_i    (rx_i.rx_byte),
    .ready_o   (rx_i.ready),
    .consume_i (consume),
    .valid_o   (byte_valid),
    .byte_o    (byte_q)
  );

  flcc_line_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_q),
    .slot_free_i  (slot_free),
    .consume_o    (consume),
    .res_load_o   (res_load),
    .res_o        (res_next)
  );

  flcc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .res_i       (res_next),
    .slot_free_o (slot_free),
    .valid_o     (res_o.valid),
    .ready_i     (res_o.ready),
    .res_o       (res_q)
  );

  // Drive the result payload
  assign res_o.line_class     = res_q.line_class;
  assign res_o.verdict        = res_q.verdict;
  assign res_o.expected_crc   = res_q.expected_crc;
  assign res_o.computed_crc   = res_q.computed_crc;
  assign res_o.lines_counted  = res_q.lines_counted;
  assign res_o.errors_counted = res_q.errors_counted;
endmodule

// ===== dv/testbench.sv =====
// Testbench for the framed line CRC checker: random text lines checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import flcc_pkg::*;

  localparam logic [7:0] EOL = 8'h0a;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTE_TARGET = 1900;

  logic clk_i;
  logic rst_ni;

  flcc_byte_if   rx_if ();
  flcc_result_if res_if ();

  framed_line_crc_checker_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // Predicted line state
  logic [4:0]  m_pos;
  logic [3:0]  m_flags;
  wrap_phase_e m_phase;
  logic [15:0] m_wrap_crc;
  logic        m_pending;
  logic [15:0] m_seed;
  logic [15:0] m_tail;
  logic [15:0] m_line_crc;
  logic [15:0] m_lines;
  logic [15:0] m_errors;

  result_t     line_results_q[$];
  logic [7:0]  line_bytes[$];
  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  int unsigned hold_off_cycles;
  bit          no_idle;

  // Clock and reset
  initial begin
    clk_i = 1'b0;
  end
  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // CRC-16, poly 0x1021, one data bit at a time, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ d[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ 16'h1021;
    end
    return r;
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_dec(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Flag bit k tracks prefix k
  function automatic string prefix_text(input int k);
    case (k)
      0: return "WRAP ";
      1: return "SCAN_RESULT ";
      2: return "Wrote stuff in ";
      default: return "Unable to make ";
    endcase
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hffff) ? c : c + 16'd1;
  endfunction

  function automatic void reset_predictor();
    m_pos      = '0;
    m_flags    = 4'hf;
    m_phase    = PH_IDLE;
    m_wrap_crc = '0;
    m_pending  = 1'b0;
    m_seed     = '0;
    m_tail     = 16'hffff;
    m_line_crc = 16'hffff;
    m_lines    = '0;
    m_errors   = '0;
  endfunction

  // Advance the line state by one byte; queue a result at each newline
  function automatic void predict_byte(input logic [7:0] b);
    logic [4:0] pos;
    int         h;
    string      p;
    result_t    r;
    pos = m_pos;
    h   = hex_digit(b);
    m_line_crc = crc16_step(m_line_crc, b);

    case (m_phase)
      PH_BEFORE_HEX: begin
        if (b != " ") begin
          if (h >= 0) begin
            m_wrap_crc = {m_wrap_crc[11:0], 4'(h)};
            m_phase    = PH_IN_HEX;
          end else begin
            m_phase = PH_FAILED;
          end
        end
      end
      PH_IN_HEX: begin
        if (h >= 0) begin
          m_wrap_crc = {m_wrap_crc[11:0], 4'(h)};
        end else if (b == " ") begin
          m_tail  = 16'hffff;
          m_phase = PH_BEFORE_DEC;
        end else begin
          m_phase = PH_FAILED;
        end
      end
      PH_BEFORE_DEC: begin
        m_tail = crc16_step(m_tail, b);
        if (is_dec(b)) begin
          if (b != "0") m_pending = 1'b1;
          m_phase = PH_IN_DEC;
        end else if (b != " ") begin
          m_phase = PH_FAILED;
        end
      end
      PH_IN_DEC: begin
        m_tail = crc16_step(m_tail, b);
        if (is_dec(b)) begin
          if (b != "0") m_pending = 1'b1;
        end else begin
          m_seed  = ~m_tail;
          m_phase = PH_DONE;
        end
      end
      default: ;
    endcase

    for (int k = 0; k < 4; k++) begin
      p = prefix_text(k);
      if (pos < p.len() && p[pos] != b) m_flags[k] = 1'b0;
    end

    // A WRAP prefix restarts the field parse
    if (pos == 5'd4 && m_flags[0]) begin
      m_wrap_crc = '0;
      m_pending  = 1'b0;
      m_phase    = PH_BEFORE_HEX;
    end

    if (m_pos != 5'd31) m_pos = m_pos + 5'd1;
    if (b != EOL) return;

    r.computed_crc = ~m_line_crc;
    r.verdict      = VER_NOT_CHECKED;
    if (m_flags[0]) begin
      m_lines = sat_inc(m_lines);
      if (m_phase == PH_DONE) begin
        r.line_class = CLS_WRAP_OK;
      end else begin
        r.line_class = CLS_WRAP_MALFORMED;
        m_errors     = sat_inc(m_errors);
      end
    end else if (m_flags[1]) begin
      r.line_class = CLS_SCAN_LINE;
      m_lines      = sat_inc(m_lines);
      if (!m_pending) r.verdict = VER_NO_WRAP;
      else if (m_wrap_crc != r.computed_crc) r.verdict = VER_BAD_CRC;
      else r.verdict = VER_OK;
      if (r.verdict != VER_OK) m_errors = sat_inc(m_errors);
      m_pending = 1'b0;
    end else if (m_flags[3:2] != 2'b00) begin
      r.line_class = CLS_INFO;
    end else begin
      r.line_class = CLS_OTHER;
      m_lines      = sat_inc(m_lines);
      m_errors     = sat_inc(m_errors);
    end
    r.expected_crc   = m_wrap_crc;
    r.lines_counted  = m_lines;
    r.errors_counted = m_errors;
    line_results_q.push_back(r);

    m_pos      = '0;
    m_flags    = 4'hf;
    m_phase    = PH_IDLE;
    m_tail     = 16'hffff;
    m_line_crc = ~m_seed;
  endfunction

  // Offer one byte and hold it until the beat is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  // Line building
  function automatic void put_byte(input logic [7:0] b);
    line_bytes.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  // Random bytes, never a newline
  function automatic void put_noise(input int n, input bit printable);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = printable ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
      if (b == EOL) b = 8'h00;
      line_bytes.push_back(b);
    end
  endfunction

  function automatic void put_spaces(input int n);
    for (int i = 0; i < n; i++) line_bytes.push_back(" ");
  endfunction

  // Digits above the low four are random since only 16 bits are kept
  function automatic void put_hex(input logic [15:0] v, input int nd);
    logic [3:0] nib;
    for (int i = nd - 1; i >= 0; i--) begin
      nib = (i < 4) ? v[4*i +: 4] : 4'($urandom_range(0, 15));
      if (nib < 4'd10) line_bytes.push_back(8'("0" + nib));
      else if ($urandom_range(0, 1)) line_bytes.push_back(8'("A" + nib - 4'd10));
      else line_bytes.push_back(8'("a" + nib - 4'd10));
    end
  endfunction

  function automatic void put_dec(input bit nonzero);
    int n;
    int last;
    n    = $urandom_range(1, 5);
    last = line_bytes.size() + n - 1;
    for (int i = 0; i < n; i++) begin
      line_bytes.push_back(nonzero ? 8'("0" + $urandom_range(0, 9)) : 8'("0"));
    end
    if (nonzero && line_bytes[last] == "0") line_bytes[last] = 8'("0" + $urandom_range(1, 9));
  endfunction

  function automatic logic [15:0] crc_span(input logic [15:0] c);
    logic [15:0] r;
    r = c;
    foreach (line_bytes[i]) r = crc16_step(r, line_bytes[i]);
    return r;
  endfunction

  // WRAP line with the checksum of the scan line sent after it, one bit flipped when corrupt is set
  task automatic framed_pair(input bit nonzero, input bit corrupt, input bit with_info);
    logic [7:0]  tail_q[$];
    logic [7:0]  scan_q[$];
    logic [15:0] tail_crc;
    logic [15:0] scan_crc;
    bit          ends_line;
    // decimal field and its terminator
    put_spaces($urandom_range(0, 2));
    put_dec(nonzero);
    ends_line = $urandom_range(0, 2) == 0;
    if (ends_line) put_byte(EOL);
    else if ($urandom_range(0, 1)) put_byte(" ");
    else put_byte(8'($urandom_range(58, 126)));
    tail_crc = crc_span(16'hffff);
    tail_q   = line_bytes;
    line_bytes.delete();
    // scan line chained from the new seed
    put_text("SCAN_RESULT ");
    put_noise($urandom_range(0, 12), $urandom_range(0, 3) != 0);
    put_byte(EOL);
    scan_crc = ~crc_span(tail_crc);
    scan_q   = line_bytes;
    line_bytes.delete();
    if (corrupt) scan_crc = scan_crc ^ (16'd1 << $urandom_range(0, 15));
    // wrap line
    put_text("WRAP ");
    put_spaces($urandom_range(0, 2));
    put_hex(scan_crc, $urandom_range(4, 6));
    put_byte(" ");
    foreach (tail_q[i]) put_byte(tail_q[i]);
    if (!ends_line) begin
      put_noise($urandom_range(0, 6), 1'b1);
      put_byte(EOL);
    end
    send_line();
    if (with_info) begin
      put_text($urandom_range(0, 1) ? "Wrote stuff in " : "Unable to make ");
      put_noise($urandom_range(0, 8), 1'b1);
      put_byte(EOL);
      send_line();
    end
    line_bytes = scan_q;
    send_line();
  endtask

  task automatic malformed_wrap(input int variant);
    case (variant)
      0: put_text("WRAP \n");
      1: put_text("WRAP +12 3\n");
      2: put_text("WRAP 0x1f 3\n");
      3: put_text("WRAP 12\n");
      4: put_text("WRAP 12 \n");
      5: put_text("WRAP 12 -3\n");
      6: put_text("WRAP 12z 3\n");
      default: put_text("WRAP g 1\n");
    endcase
    send_line();
  endtask

  // Random well-formed WRAP line, no matching scan line
  task automatic lone_wrap();
    put_text("WRAP ");
    put_spaces($urandom_range(0, 2));
    put_hex(16'($urandom), $urandom_range(1, 6));
    put_byte(" ");
    put_spaces($urandom_range(0, 2));
    put_dec($urandom_range(0, 3) != 0);
    put_byte(EOL);
    send_line();
  endtask

  // Check one result beat against the oldest expectation
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (line_results_q.size() == 0) begin
        $error("result beat with no line pending");
        fail_count++;
      end else begin
        exp_r = line_results_q.pop_front();
        check_field("line_class", 16'(exp_r.line_class), 16'(res_if.line_class));
        check_field("verdict", 16'(exp_r.verdict), 16'(res_if.verdict));
        check_field("expected_crc", exp_r.expected_crc, res_if.expected_crc);
        check_field("computed_crc", exp_r.computed_crc, res_if.computed_crc);
        check_field("lines_counted", exp_r.lines_counted, res_if.lines_counted);
        check_field("errors_counted", exp_r.errors_counted, res_if.errors_counted);
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_cycles > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk_i);
        hold_off_cycles = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  // Test tasks
  task automatic test_wrap_forms();
    put_text("WRAP 1A2b 5\n");
    send_line();
    put_text("WRAP   FFFFF 0\n");
    send_line();
    for (int v = 0; v < 8; v++) malformed_wrap(v);
  endtask

  task automatic test_scan_verdicts();
    put_text("SCAN_RESULT x\n");
    send_line();
    framed_pair(1'b1, 1'b0, 1'b0);
    framed_pair(1'b1, 1'b1, 1'b1);
    framed_pair(1'b0, 1'b0, 1'b0);
    put_text("SCAN_RESULT \n");
    send_line();
  endtask

  task automatic test_other_lines();
    put_text("Wrote stuff in a\n");
    send_line();
    put_text("Unable to make b\n");
    send_line();
    put_text("Wrote stuff i\n");
    send_line();
    put_text("\n");
    send_line();
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(EOL);
    send_line();
    put_noise(40, 1'b0);
    put_byte(EOL);
    send_line();
  endtask

  // Hold off results while short lines keep arriving back to back
  task automatic test_result_backpressure();
    no_idle = 1'b1;
    hold_off_cycles = 200;
    for (int i = 0; i < 30; i++) begin
      put_noise($urandom_range(0, 2), 1'b1);
      put_byte(EOL);
      send_line();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_lines();
    int pick;
    string p;
    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        framed_pair($urandom_range(0, 7) != 0, $urandom_range(0, 4) == 0,
                    $urandom_range(0, 5) == 0);
      end else if (pick < 50) begin
        put_text(prefix_text($urandom_range(2, 3)));
        put_noise($urandom_range(0, 20), 1'b1);
        put_byte(EOL);
        send_line();
      end else if (pick < 60) begin
        malformed_wrap($urandom_range(0, 7));
      end else if (pick < 70) begin
        put_text("SCAN_RESULT ");
        put_noise($urandom_range(0, 10), 1'b0);
        put_byte(EOL);
        send_line();
      end else if (pick < 80) begin
        lone_wrap();
      end else if (pick < 90) begin
        // cut a prefix short and break it
        p = prefix_text($urandom_range(0, 3));
        for (int i = $urandom_range(0, p.len() - 1); i > 0; i--) put_byte(p[p.len() - i - 1]);
        line_bytes.reverse();
        put_noise($urandom_range(1, 10), 1'b0);
        put_byte(EOL);
        send_line();
      end else begin
        put_noise($urandom_range(0, 40), 1'b0);
        put_byte(EOL);
        send_line();
      end
    end
    no_idle = 1'b0;
  endtask

  // Sequence of tests and end of run
  initial begin
    fail_count      = 0;
    bytes_sent      = 0;
    cycle_count     = 0;
    hold_off_cycles = 0;
    no_idle         = 1'b0;
    reset_predictor();
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    test_wrap_forms();
    test_scan_verdicts();
    test_other_lines();
    test_result_backpressure();
    test_random_lines();

    rx_if.valid <= 1'b0;
    while (line_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/flcc_pkg.sv
hw/rtl/flcc_if.sv
hw/rtl/flcc_in_stage.sv
hw/rtl/flcc_line_engine.sv
hw/rtl/flcc_out_stage.sv
hw/rtl/framed_line_crc_checker_unit.sv
dv/testbench.sv
